>>> rtl/vt52_pkg.sv
// Shared types, constants and helpers for the VT-52 terminal engine.
`default_nettype none
package vt52_pkg;

   localparam int MAX_COLUMNS = 80;
   localparam int MAX_ROWS    = 25;
   localparam int COL_W       = 7;
   localparam int ROW_W       = 5;
   localparam int CHAR_W      = 8;
   localparam int ATTR_W      = 6;
   localparam int CELL_W      = CHAR_W + ATTR_W;
   localparam int DEPTH       = MAX_COLUMNS * MAX_ROWS;
   localparam int ADDR_W      = $clog2(DEPTH);
   localparam int CSR_IDX_W   = 3;
   localparam int TAB_ACC_W   = COL_W + 1;

   localparam logic [COL_W-1:0] NCOL_MAX = COL_W'(MAX_COLUMNS);
   localparam logic [ROW_W-1:0] NROW_MAX = ROW_W'(MAX_ROWS);

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_COLUMNS   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TAB_WIDTH = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TAB_SPACE = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BS_ERASE  = 3'd4;

   // Control characters.
   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_BEL   = 8'h07;
   localparam logic [7:0] CH_BS    = 8'h08;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_ESC   = 8'h1B;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] ADDR_BIAS = 8'h20;

   // Escape letters.
   localparam logic [7:0] LT_FG        = "b";
   localparam logic [7:0] LT_BG        = "c";
   localparam logic [7:0] LT_SETF      = "y";
   localparam logic [7:0] LT_CLRF      = "z";
   localparam logic [7:0] LT_ADDR      = "Y";
   localparam logic [7:0] LT_ERASE_SOP = "d";
   localparam logic [7:0] LT_SHOW      = "e";
   localparam logic [7:0] LT_HIDE      = "f";
   localparam logic [7:0] LT_SAVE      = "j";
   localparam logic [7:0] LT_RESTORE   = "k";
   localparam logic [7:0] LT_ERASE_LN  = "l";
   localparam logic [7:0] LT_ERASE_SOL = "o";
   localparam logic [7:0] LT_SO_ON     = "p";
   localparam logic [7:0] LT_SO_OFF    = "q";
   localparam logic [7:0] LT_WRAP_ON   = "v";
   localparam logic [7:0] LT_WRAP_OFF  = "w";
   localparam logic [7:0] LT_UP        = "A";
   localparam logic [7:0] LT_DOWN      = "B";
   localparam logic [7:0] LT_RIGHT     = "C";
   localparam logic [7:0] LT_LEFT      = "D";
   localparam logic [7:0] LT_CLEAR     = "E";
   localparam logic [7:0] LT_HOME      = "H";
   localparam logic [7:0] LT_RINDEX    = "I";
   localparam logic [7:0] LT_ERASE_EOP = "J";
   localparam logic [7:0] LT_ERASE_EOL = "K";
   localparam logic [7:0] LT_INS_LINE  = "L";
   localparam logic [7:0] LT_DEL_LINE  = "M";

   localparam logic [ATTR_W-1:0] ATTR_STANDOUT = 6'h20;
   localparam logic [CELL_W-1:0] BLANK_CELL    = {CH_SPACE, 6'h00};

   typedef struct packed {
      logic [COL_W-1:0] screen_columns;
      logic [ROW_W-1:0] screen_rows;
      logic [COL_W-1:0] tab_width;
      logic             tab_writes_spaces;
      logic             backspace_erases;
   } cfg_type;

   typedef struct packed {
      logic             kind;
      logic [7:0]       byte_in;
      logic [ROW_W-1:0] read_row;
      logic [COL_W-1:0] read_col;
   } req_type;

   typedef struct packed {
      logic [CHAR_W-1:0] cell_char;
      logic [ATTR_W-1:0] cell_attr;
      logic [COL_W-1:0]  cur_col;
      logic [ROW_W-1:0]  cur_row;
      logic              cursor_visible;
      logic              bell_pulse;
      logic              escape_pending;
      logic [7:0]        fg_color;
      logic [7:0]        bg_color;
      logic [ATTR_W-1:0] write_attr;
   } rsp_type;

   typedef enum logic [2:0] {
      PH_TEXT, PH_ESC, PH_ROW, PH_COL, PH_FG, PH_BG, PH_SETF, PH_CLRF
   } phase_type;

   typedef enum logic [2:0] {
      ST_CLEAR, ST_IDLE, ST_READ, ST_TAB, ST_FILL, ST_COPY, ST_RESP
   } state_type;

   function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                   input logic [COL_W-1:0] col);
      return ADDR_W'(row) * ADDR_W'(MAX_COLUMNS) + ADDR_W'(col);
   endfunction

endpackage
`default_nettype wire

>>> rtl/vt52_ram.sv
// Generic memory with one write port and one registered read port.
`default_nettype none
module vt52_ram #(
   parameter int WIDTH  = 14,
   parameter int DEPTH  = 2000,
   parameter int ADDR_W = 11
) (
   input  wire logic              clock,
   input  wire logic              we,
   input  wire logic [ADDR_W-1:0] waddr,
   input  wire logic [WIDTH-1:0]  wdata,
   input  wire logic [ADDR_W-1:0] raddr,
   output logic      [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

>>> rtl/vt52_ctrl.sv
// Escape parser and screen store sequencer: decodes requests and walks the store.
`default_nettype none
module vt52_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire vt52_pkg::cfg_type cfg,
   input  wire logic              req_valid,
   input  wire vt52_pkg::req_type req_data,
   output logic                   req_ready,
   input  wire logic              can_push,
   output logic                   rsp_push,
   output vt52_pkg::rsp_type      rsp_data
);

   localparam int CW = vt52_pkg::COL_W;
   localparam int RW = vt52_pkg::ROW_W;
   localparam int AW = vt52_pkg::ADDR_W;
   localparam int EW = vt52_pkg::CELL_W;
   localparam int TW = vt52_pkg::TAB_ACC_W;

   vt52_pkg::state_type state_ff, state_in;
   vt52_pkg::phase_type phase_ff, phase_in;

   logic [CW-1:0] col_ff, col_in, sav_col_ff, sav_col_in;
   logic [RW-1:0] row_ff, row_in, sav_row_ff, sav_row_in;
   logic [vt52_pkg::ATTR_W-1:0] attr_ff, attr_in;
   logic          wrap_ff, wrap_in, shown_ff, shown_in, bell_ff, bell_in;
   logic [7:0]    pend_ff, pend_in, fg_ff, fg_in, bg_ff, bg_in;
   logic [EW-1:0] cell_ff, cell_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic          clr_step_ff, clr_step_in;
   logic [RW-1:0] fy_ff, fy_in, fey_ff, fey_in;
   logic [CW-1:0] fx_ff, fx_in, fex_ff, fex_in;
   logic [EW-1:0] fdat_ff, fdat_in;
   logic [RW-1:0] cy_ff, cy_in, ctop_ff, ctop_in;
   logic [CW-1:0] ccol_ff, ccol_in, rd_col_ff, rd_col_in;
   logic          cup_ff, cup_in, rd_pend_ff, rd_pend_in;
   logic [TW-1:0] tk_ff, tk_in;

   // Job launch requests raised by the decode and walk logic.
   logic          fgo, cgo, cgo_up;
   logic [RW-1:0] fsy, fey, cgo_top;
   logic [CW-1:0] fsx, fex;
   logic [EW-1:0] fdat;

   logic          ram_we;
   logic [AW-1:0] ram_waddr, ram_raddr;
   logic [EW-1:0] ram_wdata, ram_rdata;

   // Effective screen size and cursors clamped into it.
   logic [CW-1:0] ncols, cmax, cc, sc, tw_eff, cl_left;
   logic [RW-1:0] nrows, rmax, cr, sr;

   // Character write at the cursor, with wrap and scroll.
   logic [CW-1:0] put_col, pcol;
   logic [CW:0]   put_next;
   logic [RW-1:0] prow;
   logic          pscroll;
   logic [EW-1:0] put_data;

   logic [7:0]    dx, dy;
   logic [CW-1:0] nx;
   logic          more_rows;
   logic [RW-1:0] csrc;

   vt52_ram #(
      .WIDTH (vt52_pkg::CELL_W),
      .DEPTH (vt52_pkg::DEPTH),
      .ADDR_W(vt52_pkg::ADDR_W)
   ) u_store (
      .clock(clock),
      .we   (ram_we),
      .waddr(ram_waddr),
      .wdata(ram_wdata),
      .raddr(ram_raddr),
      .rdata(ram_rdata)
   );

   always_comb begin
      if (cfg.screen_columns == '0) begin
         ncols = CW'(1);
      end else if (cfg.screen_columns > vt52_pkg::NCOL_MAX) begin
         ncols = vt52_pkg::NCOL_MAX;
      end else begin
         ncols = cfg.screen_columns;
      end
      if (cfg.screen_rows == '0) begin
         nrows = RW'(1);
      end else if (cfg.screen_rows > vt52_pkg::NROW_MAX) begin
         nrows = vt52_pkg::NROW_MAX;
      end else begin
         nrows = cfg.screen_rows;
      end
      cmax    = ncols - CW'(1);
      rmax    = nrows - RW'(1);
      cc      = (col_ff > cmax) ? cmax : col_ff;
      cr      = (row_ff > rmax) ? rmax : row_ff;
      sc      = (sav_col_ff > cmax) ? cmax : sav_col_ff;
      sr      = (sav_row_ff > rmax) ? rmax : sav_row_ff;
      tw_eff  = (cfg.tab_width == '0) ? CW'(1) : cfg.tab_width;
      cl_left = (cc != '0) ? cc - CW'(1) : '0;
   end

   always_comb begin
      put_col  = (req_data.byte_in == vt52_pkg::CH_BS) ? cl_left : cc;
      put_data = {(req_data.byte_in == vt52_pkg::CH_BS) ? vt52_pkg::CH_SPACE
                                                          : req_data.byte_in, attr_ff};
      put_next = {1'b0, put_col} + (CW+1)'(1);
      prow     = cr;
      pscroll  = 1'b0;
      if (put_next < {1'b0, ncols}) begin
         pcol = put_next[CW-1:0];
      end else if (wrap_ff) begin
         pcol = '0;
         if (cr < rmax) begin
            prow = cr + RW'(1);
         end else begin
            pscroll = 1'b1;
         end
      end else begin
         pcol = cmax;
      end
      // Direct addressing: bytes are biased by a space and clamped into the area.
      dx = (req_data.byte_in < vt52_pkg::ADDR_BIAS) ? 8'd0
                                                   : req_data.byte_in - vt52_pkg::ADDR_BIAS;
      dy = (pend_ff < vt52_pkg::ADDR_BIAS) ? 8'd0 : pend_ff - vt52_pkg::ADDR_BIAS;
      nx = (tk_ff > TW'(cmax)) ? cmax : tk_ff[CW-1:0];
      more_rows = cup_ff ? ((RW+1)'(cy_ff) + (RW+1)'(1) < (RW+1)'(nrows))
                         : (cy_ff > ctop_ff);
      csrc = cup_ff ? cy_ff + RW'(1) : cy_ff - RW'(1);
   end

   always_comb begin
      state_in    = state_ff;
      phase_in    = phase_ff;
      col_in      = cc;
      row_in      = cr;
      sav_col_in  = sc;
      sav_row_in  = sr;
      attr_in     = attr_ff;
      wrap_in     = wrap_ff;
      shown_in    = shown_ff;
      bell_in     = bell_ff;
      pend_in     = pend_ff;
      fg_in       = fg_ff;
      bg_in       = bg_ff;
      cell_in     = cell_ff;
      clr_in      = clr_ff;
      clr_step_in = clr_step_ff;
      fy_in       = fy_ff;
      fx_in       = fx_ff;
      fey_in      = fey_ff;
      fex_in      = fex_ff;
      fdat_in     = fdat_ff;
      cy_in       = cy_ff;
      ctop_in     = ctop_ff;
      cup_in      = cup_ff;
      ccol_in     = ccol_ff;
      rd_pend_in  = 1'b0;
      rd_col_in   = rd_col_ff;
      tk_in       = tk_ff;
      ram_we      = 1'b0;
      ram_waddr   = '0;
      ram_wdata   = '0;
      ram_raddr   = '0;
      req_ready   = 1'b0;
      rsp_push    = 1'b0;
      fgo         = 1'b0;
      fsy         = '0;
      fsx         = '0;
      fey         = '0;
      fex         = '0;
      fdat        = vt52_pkg::BLANK_CELL;
      cgo         = 1'b0;
      cgo_up      = 1'b0;
      cgo_top     = '0;

      case (state_ff)
         vt52_pkg::ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            ram_wdata = vt52_pkg::BLANK_CELL;
            if (clr_ff == AW'(vt52_pkg::DEPTH - 1)) begin
               clr_in   = '0;
               state_in = clr_step_ff ? vt52_pkg::ST_RESP : vt52_pkg::ST_IDLE;
            end else begin
               clr_in = clr_ff + AW'(1);
            end
         end
         vt52_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               bell_in  = 1'b0;
               cell_in  = '0;
               state_in = vt52_pkg::ST_RESP;
               if (req_data.kind) begin
                  if (req_data.read_row < vt52_pkg::NROW_MAX &&
                      req_data.read_col < vt52_pkg::NCOL_MAX) begin
                     ram_raddr = vt52_pkg::cell_addr(req_data.read_row, req_data.read_col);
                     state_in  = vt52_pkg::ST_READ;
                  end
               end else begin
                  case (phase_ff)
                     vt52_pkg::PH_ESC: begin
                        phase_in = vt52_pkg::PH_TEXT;
                        case (req_data.byte_in)
                           vt52_pkg::LT_FG:      phase_in = vt52_pkg::PH_FG;
                           vt52_pkg::LT_BG:      phase_in = vt52_pkg::PH_BG;
                           vt52_pkg::LT_SETF:    phase_in = vt52_pkg::PH_SETF;
                           vt52_pkg::LT_CLRF:    phase_in = vt52_pkg::PH_CLRF;
                           vt52_pkg::LT_ADDR:    phase_in = vt52_pkg::PH_ROW;
                           vt52_pkg::LT_ERASE_SOP: begin
                              fgo = 1'b1;
                              fey = cr;
                              fex = cc;
                           end
                           vt52_pkg::LT_SHOW:    shown_in = 1'b1;
                           vt52_pkg::LT_HIDE:    shown_in = 1'b0;
                           vt52_pkg::LT_SAVE: begin
                              sav_col_in = cc;
                              sav_row_in = cr;
                           end
                           vt52_pkg::LT_RESTORE: begin
                              col_in = sc;
                              row_in = sr;
                           end
                           vt52_pkg::LT_ERASE_LN: begin
                              fgo    = 1'b1;
                              fsy    = cr;
                              fey    = cr + RW'(1);
                              col_in = '0;
                           end
                           vt52_pkg::LT_ERASE_SOL: begin
                              fgo = 1'b1;
                              fsy = cr;
                              fey = cr;
                              fex = cc;
                           end
                           vt52_pkg::LT_SO_ON:   attr_in = attr_ff | vt52_pkg::ATTR_STANDOUT;
                           vt52_pkg::LT_SO_OFF:  attr_in = attr_ff & ~vt52_pkg::ATTR_STANDOUT;
                           vt52_pkg::LT_WRAP_ON:  wrap_in = 1'b1;
                           vt52_pkg::LT_WRAP_OFF: wrap_in = 1'b0;
                           vt52_pkg::LT_UP: begin
                              if (cr != '0) row_in = cr - RW'(1);
                           end
                           vt52_pkg::LT_DOWN: begin
                              if (cr < rmax) row_in = cr + RW'(1);
                           end
                           vt52_pkg::LT_RIGHT: begin
                              if (cc < cmax) col_in = cc + CW'(1);
                           end
                           vt52_pkg::LT_LEFT:    col_in = cl_left;
                           vt52_pkg::LT_CLEAR: begin
                              col_in      = '0;
                              row_in      = '0;
                              clr_in      = '0;
                              clr_step_in = 1'b1;
                              state_in    = vt52_pkg::ST_CLEAR;
                           end
                           vt52_pkg::LT_HOME: begin
                              col_in = '0;
                              row_in = '0;
                           end
                           vt52_pkg::LT_RINDEX: begin
                              if (cr != '0) begin
                                 row_in = cr - RW'(1);
                              end else begin
                                 cgo = 1'b1;
                              end
                           end
                           vt52_pkg::LT_ERASE_EOP: begin
                              fgo = 1'b1;
                              fsy = cr;
                              fsx = cc;
                              fey = nrows;
                           end
                           vt52_pkg::LT_ERASE_EOL: begin
                              fgo = 1'b1;
                              fsy = cr;
                              fsx = cc;
                              fey = cr + RW'(1);
                           end
                           vt52_pkg::LT_INS_LINE: begin
                              cgo     = 1'b1;
                              cgo_top = cr;
                              col_in  = '0;
                           end
                           vt52_pkg::LT_DEL_LINE: begin
                              cgo     = 1'b1;
                              cgo_up  = 1'b1;
                              cgo_top = cr;
                              col_in  = '0;
                           end
                           default: ;
                        endcase
                     end
                     vt52_pkg::PH_ROW: begin
                        pend_in  = req_data.byte_in;
                        phase_in = vt52_pkg::PH_COL;
                     end
                     vt52_pkg::PH_COL: begin
                        col_in   = (dx > {1'b0, cmax}) ? cmax : dx[CW-1:0];
                        row_in   = (dy > 8'(rmax)) ? rmax : dy[RW-1:0];
                        phase_in = vt52_pkg::PH_TEXT;
                     end
                     vt52_pkg::PH_FG: begin
                        fg_in    = req_data.byte_in;
                        phase_in = vt52_pkg::PH_TEXT;
                     end
                     vt52_pkg::PH_BG: begin
                        bg_in    = req_data.byte_in;
                        phase_in = vt52_pkg::PH_TEXT;
                     end
                     vt52_pkg::PH_SETF: begin
                        attr_in  = attr_ff | {1'b0, req_data.byte_in[4:0]};
                        phase_in = vt52_pkg::PH_TEXT;
                     end
                     vt52_pkg::PH_CLRF: begin
                        attr_in  = attr_ff & ~{1'b0, req_data.byte_in[4:0]};
                        phase_in = vt52_pkg::PH_TEXT;
                     end
                     default: begin
                        phase_in = vt52_pkg::PH_TEXT;
                        case (req_data.byte_in)
                           vt52_pkg::CH_ESC: phase_in = vt52_pkg::PH_ESC;
                           vt52_pkg::CH_TAB: begin
                              tk_in    = TW'(tw_eff);
                              state_in = vt52_pkg::ST_TAB;
                           end
                           vt52_pkg::CH_CR:  col_in = '0;
                           vt52_pkg::CH_LF: begin
                              if (cr < rmax) begin
                                 row_in = cr + RW'(1);
                              end else begin
                                 cgo    = 1'b1;
                                 cgo_up = 1'b1;
                              end
                           end
                           vt52_pkg::CH_BEL: bell_in = 1'b1;
                           vt52_pkg::CH_BS: begin
                              col_in = cl_left;
                              if (cfg.backspace_erases) begin
                                 ram_we    = 1'b1;
                                 ram_waddr = vt52_pkg::cell_addr(cr, put_col);
                                 ram_wdata = put_data;
                                 col_in    = (pcol != '0) ? pcol - CW'(1) : '0;
                                 row_in    = prow;
                                 cgo       = pscroll;
                                 cgo_up    = 1'b1;
                              end
                           end
                           vt52_pkg::CH_NUL: ;
                           default: begin
                              ram_we    = 1'b1;
                              ram_waddr = vt52_pkg::cell_addr(cr, put_col);
                              ram_wdata = put_data;
                              col_in    = pcol;
                              row_in    = prow;
                              cgo       = pscroll;
                              cgo_up    = 1'b1;
                           end
                        endcase
                     end
                  endcase
               end
            end
         end
         vt52_pkg::ST_READ: begin
            cell_in  = ram_rdata;
            state_in = vt52_pkg::ST_RESP;
         end
         vt52_pkg::ST_TAB: begin
            if (tk_ff > TW'(cc)) begin
               col_in   = nx;
               state_in = vt52_pkg::ST_RESP;
               if (cfg.tab_writes_spaces && nx > cc) begin
                  fgo  = 1'b1;
                  fsy  = cr;
                  fsx  = cc;
                  fey  = cr;
                  fex  = nx;
                  fdat = {vt52_pkg::CH_SPACE, attr_ff};
               end
            end else begin
               tk_in = tk_ff + TW'(tw_eff);
            end
         end
         vt52_pkg::ST_FILL: begin
            if (fy_ff == fey_ff && fx_ff == fex_ff) begin
               state_in = vt52_pkg::ST_RESP;
            end else if (fx_ff >= ncols) begin
               fy_in = fy_ff + RW'(1);
               fx_in = '0;
            end else begin
               ram_we    = 1'b1;
               ram_waddr = vt52_pkg::cell_addr(fy_ff, fx_ff);
               ram_wdata = fdat_ff;
               fx_in     = fx_ff + CW'(1);
            end
         end
         vt52_pkg::ST_COPY: begin
            if (ccol_ff == '0 && !rd_pend_ff && !more_rows) begin
               // All rows moved: blank the row that was vacated.
               fgo = 1'b1;
               fsy = cup_ff ? rmax : ctop_ff;
               fey = fsy + RW'(1);
            end else begin
               if (ccol_ff < ncols) begin
                  ram_raddr  = vt52_pkg::cell_addr(csrc, ccol_ff);
                  rd_pend_in = 1'b1;
                  rd_col_in  = ccol_ff;
                  ccol_in    = ccol_ff + CW'(1);
               end
               if (rd_pend_ff) begin
                  ram_we    = 1'b1;
                  ram_waddr = vt52_pkg::cell_addr(cy_ff, rd_col_ff);
                  ram_wdata = ram_rdata;
               end
               if (ccol_ff == ncols && !rd_pend_ff) begin
                  cy_in   = cup_ff ? cy_ff + RW'(1) : cy_ff - RW'(1);
                  ccol_in = '0;
               end
            end
         end
         vt52_pkg::ST_RESP: begin
            if (can_push) begin
               rsp_push = 1'b1;
               state_in = vt52_pkg::ST_IDLE;
            end
         end
         default: state_in = vt52_pkg::ST_IDLE;
      endcase

      if (fgo) begin
         fy_in    = fsy;
         fx_in    = fsx;
         fey_in   = fey;
         fex_in   = fex;
         fdat_in  = fdat;
         state_in = vt52_pkg::ST_FILL;
      end
      if (cgo) begin
         cup_in     = cgo_up;
         ctop_in    = cgo_top;
         cy_in      = cgo_up ? cgo_top : rmax;
         ccol_in    = '0;
         rd_pend_in = 1'b0;
         state_in   = vt52_pkg::ST_COPY;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= vt52_pkg::ST_CLEAR;
         phase_ff    <= vt52_pkg::PH_TEXT;
         col_ff      <= '0;
         row_ff      <= '0;
         sav_col_ff  <= '0;
         sav_row_ff  <= '0;
         attr_ff     <= '0;
         wrap_ff     <= 1'b1;
         shown_ff    <= 1'b1;
         bell_ff     <= 1'b0;
         pend_ff     <= '0;
         fg_ff       <= '0;
         bg_ff       <= '0;
         clr_ff      <= '0;
         clr_step_ff <= 1'b0;
         rd_pend_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         phase_ff    <= phase_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
         sav_col_ff  <= sav_col_in;
         sav_row_ff  <= sav_row_in;
         attr_ff     <= attr_in;
         wrap_ff     <= wrap_in;
         shown_ff    <= shown_in;
         bell_ff     <= bell_in;
         pend_ff     <= pend_in;
         fg_ff       <= fg_in;
         bg_ff       <= bg_in;
         clr_ff      <= clr_in;
         clr_step_ff <= clr_step_in;
         rd_pend_ff  <= rd_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      cell_ff   <= cell_in;
      fy_ff     <= fy_in;
      fx_ff     <= fx_in;
      fey_ff    <= fey_in;
      fex_ff    <= fex_in;
      fdat_ff   <= fdat_in;
      cy_ff     <= cy_in;
      ctop_ff   <= ctop_in;
      cup_ff    <= cup_in;
      ccol_ff   <= ccol_in;
      rd_col_ff <= rd_col_in;
      tk_ff     <= tk_in;
   end

   always_comb begin
      rsp_data.cell_char      = cell_ff[EW-1:vt52_pkg::ATTR_W];
      rsp_data.cell_attr      = cell_ff[vt52_pkg::ATTR_W-1:0];
      rsp_data.cur_col        = col_ff;
      rsp_data.cur_row        = row_ff;
      rsp_data.cursor_visible = shown_ff;
      rsp_data.bell_pulse     = bell_ff;
      rsp_data.escape_pending = (phase_ff != vt52_pkg::PH_TEXT);
      rsp_data.fg_color       = fg_ff;
      rsp_data.bg_color       = bg_ff;
      rsp_data.write_attr     = attr_ff;
   end

endmodule
`default_nettype wire

>>> rtl/vt52_terminal_engine.sv
// Top level of the VT-52 terminal engine: configuration registers and response register.
`default_nettype none
// The engine interprets host bytes as a VT-52 terminal with color and font-bit
// extensions and keeps an 80 by 25 character and attribute screen store in one
// synchronous memory; a request of the read kind returns one stored cell. Every
// request produces exactly one response carrying the cursor, the parser status,
// the colors and the write attribute after the request. Plain bytes, cursor
// moves and escape parameter bytes are decoded, with the store updated, in the
// idle state and then handed to the output register from the response state. A
// cell read passes through a read state, since the store has a registered read
// port. Everything that touches many cells is walked through the store one cell
// per cycle, since the memory offers one read and one write per cycle: an erase
// writes each erased cell and steps over each row end it crosses; an insert,
// delete or scroll copies each moved row cell by cell and then blanks the
// vacated row. A tab steps through the tab stops up to the first one right of
// the cursor and, with space writing on, then writes the spaces. The
// clear-screen escape sweeps all 2000 cells. All of these run between the
// decode and the response. After reset the engine runs the same clearing pass
// before it accepts its first request; configuration writes are taken at any
// time and take effect once registered, also on a request still in progress,
// with the cursor and the saved cursor pulled into a smaller area right away. A
// finished response waits in its own register, so the next request can be taken
// while the previous response is still held.
module vt52_terminal_engine (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire vt52_pkg::req_type                  req_data,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output vt52_pkg::rsp_type                       rsp_data,
   input  wire logic                               csr_we,
   input  wire logic [vt52_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [vt52_pkg::COL_W-1:0]         csr_wdata
);

   vt52_pkg::cfg_type cfg_ff, cfg_in;
   vt52_pkg::rsp_type rsp_data_ff, ctrl_rsp;
   logic              rsp_valid_ff;
   logic              can_push, ctrl_push;

   // Configuration writes land directly; fields narrower than the port keep
   // their low bits.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            vt52_pkg::CSR_COLUMNS:   cfg_in.screen_columns    = csr_wdata;
            vt52_pkg::CSR_ROWS:      cfg_in.screen_rows       = csr_wdata[vt52_pkg::ROW_W-1:0];
            vt52_pkg::CSR_TAB_WIDTH: cfg_in.tab_width         = csr_wdata;
            vt52_pkg::CSR_TAB_SPACE: cfg_in.tab_writes_spaces = csr_wdata[0];
            vt52_pkg::CSR_BS_ERASE:  cfg_in.backspace_erases  = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.screen_columns    <= vt52_pkg::NCOL_MAX;
         cfg_ff.screen_rows       <= vt52_pkg::NROW_MAX;
         cfg_ff.tab_width         <= vt52_pkg::COL_W'(8);
         cfg_ff.tab_writes_spaces <= 1'b0;
         cfg_ff.backspace_erases  <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // The controller may hand over a response whenever the output register is
   // empty or is being emptied in the same cycle.
   assign can_push = !rsp_valid_ff || rsp_ready;

   vt52_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .req_valid(req_valid),
      .req_data (req_data),
      .req_ready(req_ready),
      .can_push (can_push),
      .rsp_push (ctrl_push),
      .rsp_data (ctrl_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctrl_push) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl_push) begin
         rsp_data_ff <= ctrl_rsp;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTH
   // The cursor of a held response always lies inside the store.
   a_cursor_in_store: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.cur_col < vt52_pkg::NCOL_MAX &&
                     rsp_data.cur_row < vt52_pkg::NROW_MAX))
      else $error("response cursor outside the screen store");

   // The controller never overwrites a response that is still held.
   a_push_has_room: assert property (@(posedge clock) disable iff (reset)
      ctrl_push |-> can_push)
      else $error("response pushed into a full output register");

   // One request at a time: the engine is busy right after taking one.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while the previous one is in flight");
`endif

endmodule
`default_nettype wire

>>> tb/sv/vt52_terminal_engine_test.sv
// Self-checking testbench for the VT-52 terminal engine.
`default_nettype none
module vt52_terminal_engine_test;

   // The bench keeps its own copy of the terminal: screen store, cursor,
   // saved cursor, parser phase, colors and the configuration. Every accepted
   // request is run through that copy, and the response that it yields is
   // queued. The monitor checks each response from the engine against the
   // oldest queued one. Stimulus runs in phases. Each phase after the first
   // begins with a full register write while the engine is idle, and then
   // follows with a batch of host bytes and cell reads.

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   vt52_pkg::req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   vt52_pkg::rsp_type rsp_data;
   logic    csr_we = 1'b0;
   logic [vt52_pkg::CSR_IDX_W-1:0] csr_index = vt52_pkg::CSR_COLUMNS;
   logic [vt52_pkg::COL_W-1:0]     csr_wdata = '0;

   vt52_terminal_engine dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   // Requests that wait for the driver, and responses still owed by the engine.
   vt52_pkg::req_type host_queue[$];
   vt52_pkg::rsp_type due_rsp[$];
   int      errors = 0;
   bit      relaxed = 1'b1;   // When set, both sides draw random idle cycles.

   // ---------------------------------------------------------------------
   // Predicted terminal state.
   // ---------------------------------------------------------------------
   logic [vt52_pkg::CHAR_W-1:0] scr_char [0:vt52_pkg::DEPTH-1];
   logic [vt52_pkg::ATTR_W-1:0] scr_attr [0:vt52_pkg::DEPTH-1];
   logic [vt52_pkg::COL_W-1:0]  cur_c, sav_c;
   logic [vt52_pkg::ROW_W-1:0]  cur_r, sav_r;
   logic [vt52_pkg::ATTR_W-1:0] wattr;
   logic                        wrap_on, shown;
   vt52_pkg::phase_type         phase;
   logic [7:0]                  row_byte, fg, bg;
   vt52_pkg::cfg_type           cfg;

   function automatic int cols_used();
      if (cfg.screen_columns == 0) return 1;
      return (cfg.screen_columns > vt52_pkg::MAX_COLUMNS) ? vt52_pkg::MAX_COLUMNS
                                                          : int'(cfg.screen_columns);
   endfunction

   function automatic int rows_used();
      if (cfg.screen_rows == 0) return 1;
      return (cfg.screen_rows > vt52_pkg::MAX_ROWS) ? vt52_pkg::MAX_ROWS
                                                    : int'(cfg.screen_rows);
   endfunction

   function automatic void blank(int r, int c0, int c1);
      for (int c = c0; c < c1; c++) begin
         scr_char[r * vt52_pkg::MAX_COLUMNS + c] = vt52_pkg::CH_SPACE;
         scr_attr[r * vt52_pkg::MAX_COLUMNS + c] = '0;
      end
   endfunction

   function automatic void wipe_store();
      for (int r = 0; r < vt52_pkg::MAX_ROWS; r++) blank(r, 0, vt52_pkg::MAX_COLUMNS);
   endfunction

   function automatic void copy_line(int dst, int src);
      for (int c = 0; c < cols_used(); c++) begin
         scr_char[dst * vt52_pkg::MAX_COLUMNS + c] = scr_char[src * vt52_pkg::MAX_COLUMNS + c];
         scr_attr[dst * vt52_pkg::MAX_COLUMNS + c] = scr_attr[src * vt52_pkg::MAX_COLUMNS + c];
      end
   endfunction

   // Cursor and saved cursor are pulled into the area in use.
   function automatic void clamp_cursor();
      int c, r;
      c = cols_used();
      r = rows_used();
      if (cur_c > c - 1) cur_c = vt52_pkg::COL_W'(c - 1);
      if (cur_r > r - 1) cur_r = vt52_pkg::ROW_W'(r - 1);
      if (sav_c > c - 1) sav_c = vt52_pkg::COL_W'(c - 1);
      if (sav_r > r - 1) sav_r = vt52_pkg::ROW_W'(r - 1);
   endfunction

   function automatic void feed_line();
      if (cur_r < rows_used() - 1) cur_r++;
      else begin
         for (int y = 1; y < rows_used(); y++) copy_line(y - 1, y);
         blank(rows_used() - 1, 0, cols_used());
      end
   endfunction

   // Stores a character at the cursor and advances, with wrap and scroll.
   function automatic void put_glyph(logic [7:0] ch);
      int nc;
      scr_char[cur_r * vt52_pkg::MAX_COLUMNS + cur_c] = ch;
      scr_attr[cur_r * vt52_pkg::MAX_COLUMNS + cur_c] = wattr;
      nc = int'(cur_c) + 1;
      if (nc >= cols_used()) begin
         if (wrap_on) begin
            cur_c = '0;
            feed_line();
         end else begin
            cur_c = vt52_pkg::COL_W'(cols_used() - 1);
         end
      end else begin
         cur_c = vt52_pkg::COL_W'(nc);
      end
   endfunction

   function automatic void tab_stop();
      int tw, nx;
      tw = (cfg.tab_width == 0) ? 1 : int'(cfg.tab_width);
      nx = (int'(cur_c) / tw) * tw + tw;
      if (nx >= cols_used()) nx = cols_used() - 1;
      if (cfg.tab_writes_spaces && nx > cur_c) begin
         for (int n = nx - int'(cur_c); n > 0; n--) put_glyph(vt52_pkg::CH_SPACE);
      end
      cur_c = vt52_pkg::COL_W'(nx);
   endfunction

   function automatic void handle_escape(logic [7:0] ch);
      int r, c;
      r = rows_used();
      c = cols_used();
      phase = vt52_pkg::PH_TEXT;
      case (ch)
         vt52_pkg::LT_FG:        phase = vt52_pkg::PH_FG;
         vt52_pkg::LT_BG:        phase = vt52_pkg::PH_BG;
         vt52_pkg::LT_SETF:      phase = vt52_pkg::PH_SETF;
         vt52_pkg::LT_CLRF:      phase = vt52_pkg::PH_CLRF;
         vt52_pkg::LT_ADDR:      phase = vt52_pkg::PH_ROW;
         vt52_pkg::LT_ERASE_SOP: begin
            blank(cur_r, 0, cur_c);
            for (int y = 0; y < cur_r; y++) blank(y, 0, c);
         end
         vt52_pkg::LT_SHOW:      shown = 1'b1;
         vt52_pkg::LT_HIDE:      shown = 1'b0;
         vt52_pkg::LT_SAVE:      begin sav_c = cur_c; sav_r = cur_r; end
         vt52_pkg::LT_RESTORE:   begin cur_c = sav_c; cur_r = sav_r; end
         vt52_pkg::LT_ERASE_LN:  begin blank(cur_r, 0, c); cur_c = '0; end
         vt52_pkg::LT_ERASE_SOL: blank(cur_r, 0, cur_c);
         vt52_pkg::LT_SO_ON:     wattr = wattr | vt52_pkg::ATTR_STANDOUT;
         vt52_pkg::LT_SO_OFF:    wattr = wattr & ~vt52_pkg::ATTR_STANDOUT;
         vt52_pkg::LT_WRAP_ON:   wrap_on = 1'b1;
         vt52_pkg::LT_WRAP_OFF:  wrap_on = 1'b0;
         vt52_pkg::LT_UP:        if (cur_r > 0) cur_r--;
         vt52_pkg::LT_DOWN:      if (cur_r < r - 1) cur_r++;
         vt52_pkg::LT_RIGHT:     if (cur_c < c - 1) cur_c++;
         vt52_pkg::LT_LEFT:      if (cur_c > 0) cur_c--;
         vt52_pkg::LT_CLEAR:     begin cur_c = '0; cur_r = '0; wipe_store(); end
         vt52_pkg::LT_HOME:      begin cur_c = '0; cur_r = '0; end
         vt52_pkg::LT_RINDEX: begin
            // At the top row the area scrolls down and row 0 is blanked.
            if (cur_r > 0) cur_r--;
            else begin
               for (int y = r - 1; y > 0; y--) copy_line(y, y - 1);
               blank(0, 0, c);
            end
         end
         vt52_pkg::LT_ERASE_EOP: begin
            blank(cur_r, cur_c, c);
            for (int y = cur_r + 1; y < r; y++) blank(y, 0, c);
         end
         vt52_pkg::LT_ERASE_EOL: blank(cur_r, cur_c, c);
         vt52_pkg::LT_INS_LINE: begin
            for (int y = r - 1; y > cur_r; y--) copy_line(y, y - 1);
            blank(cur_r, 0, c);
            cur_c = '0;
         end
         vt52_pkg::LT_DEL_LINE: begin
            for (int y = cur_r; y + 1 < r; y++) copy_line(y, y + 1);
            blank(r - 1, 0, c);
            cur_c = '0;
         end
         default: ;   // An unknown letter just ends the sequence.
      endcase
   endfunction

   // Runs one request through the predicted terminal and returns its response.
   function automatic vt52_pkg::rsp_type terminal_step(vt52_pkg::req_type q);
      vt52_pkg::rsp_type o;
      int x, y;
      o = '0;
      if (q.kind) begin
         if (q.read_row < vt52_pkg::MAX_ROWS && q.read_col < vt52_pkg::MAX_COLUMNS) begin
            o.cell_char = scr_char[q.read_row * vt52_pkg::MAX_COLUMNS + q.read_col];
            o.cell_attr = scr_attr[q.read_row * vt52_pkg::MAX_COLUMNS + q.read_col];
         end
      end else begin
         clamp_cursor();
         case (phase)
            vt52_pkg::PH_ESC:  handle_escape(q.byte_in);
            vt52_pkg::PH_ROW:  begin row_byte = q.byte_in; phase = vt52_pkg::PH_COL; end
            vt52_pkg::PH_COL: begin
               // Direct address: both bytes are biased by 32 and clamped.
               x = int'(q.byte_in) - 32;
               y = int'(row_byte) - 32;
               if (x < 0) x = 0;
               if (y < 0) y = 0;
               if (x > cols_used() - 1) x = cols_used() - 1;
               if (y > rows_used() - 1) y = rows_used() - 1;
               cur_c = vt52_pkg::COL_W'(x);
               cur_r = vt52_pkg::ROW_W'(y);
               phase = vt52_pkg::PH_TEXT;
            end
            vt52_pkg::PH_FG:   begin fg = q.byte_in; phase = vt52_pkg::PH_TEXT; end
            vt52_pkg::PH_BG:   begin bg = q.byte_in; phase = vt52_pkg::PH_TEXT; end
            vt52_pkg::PH_SETF: begin
               wattr = wattr | (q.byte_in[5:0] & 6'h1F);
               phase = vt52_pkg::PH_TEXT;
            end
            vt52_pkg::PH_CLRF: begin
               wattr = wattr & ~(q.byte_in[5:0] & 6'h1F);
               phase = vt52_pkg::PH_TEXT;
            end
            default: begin
               phase = vt52_pkg::PH_TEXT;
               case (q.byte_in)
                  vt52_pkg::CH_ESC: phase = vt52_pkg::PH_ESC;
                  vt52_pkg::CH_TAB: tab_stop();
                  vt52_pkg::CH_CR:  cur_c = '0;
                  vt52_pkg::CH_LF:  feed_line();
                  vt52_pkg::CH_BEL: o.bell_pulse = 1'b1;
                  vt52_pkg::CH_BS: begin
                     if (cur_c > 0) cur_c--;
                     if (cfg.backspace_erases) begin
                        // With one column the written space wraps like text.
                        put_glyph(vt52_pkg::CH_SPACE);
                        if (cur_c > 0) cur_c--;
                     end
                  end
                  vt52_pkg::CH_NUL: ;
                  default: put_glyph(q.byte_in);
               endcase
            end
         endcase
      end
      o.cur_col        = cur_c;
      o.cur_row        = cur_r;
      o.cursor_visible = shown;
      o.escape_pending = (phase != vt52_pkg::PH_TEXT);
      o.fg_color       = fg;
      o.bg_color       = bg;
      o.write_attr     = wattr;
      return o;
   endfunction

   // ---------------------------------------------------------------------
   // Driver: offers queued requests with random gaps between them.
   // ---------------------------------------------------------------------
   int send_gap = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap  <= 0;
      end else begin
         if (req_valid && req_ready) due_rsp.push_back(terminal_step(req_data));
         if (req_valid && !req_ready) begin
            // Hold the request until the engine takes it.
         end else if (send_gap > 0) begin
            req_valid <= 1'b0;
            send_gap  <= send_gap - 1;
         end else if (host_queue.size() > 0) begin
            req_data  <= host_queue.pop_front();
            req_valid <= 1'b1;
            send_gap  <= relaxed ? $urandom_range(0, 4) : 0;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: checks responses and stalls the result side at random.
   // ---------------------------------------------------------------------
   int      stall = 0;
   int      taken = 0;
   int      hold;
   vt52_pkg::rsp_type want;

   // Four-state compare, so an unknown response bit counts as a mismatch.
   task automatic show_diff(string field, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp_v, act_v);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         stall     <= 0;
      end else if (rsp_valid && rsp_ready) begin
         if (due_rsp.size() == 0) begin
            $display("%0t: unexpected response, expected none, actual %h", $time, rsp_data);
            errors++;
         end else begin
            want = due_rsp.pop_front();
            show_diff("cell_char", 32'(want.cell_char), 32'(rsp_data.cell_char));
            show_diff("cell_attr", 32'(want.cell_attr), 32'(rsp_data.cell_attr));
            show_diff("cur_col", 32'(want.cur_col), 32'(rsp_data.cur_col));
            show_diff("cur_row", 32'(want.cur_row), 32'(rsp_data.cur_row));
            show_diff("cursor_visible", 32'(want.cursor_visible),
                      32'(rsp_data.cursor_visible));
            show_diff("bell_pulse", 32'(want.bell_pulse), 32'(rsp_data.bell_pulse));
            show_diff("escape_pending", 32'(want.escape_pending),
                      32'(rsp_data.escape_pending));
            show_diff("fg_color", 32'(want.fg_color), 32'(rsp_data.fg_color));
            show_diff("bg_color", 32'(want.bg_color), 32'(rsp_data.bg_color));
            show_diff("write_attr", 32'(want.write_attr), 32'(rsp_data.write_attr));
         end
         taken <= taken + 1;
         // One long hold-off lets the engine fill up and push back on requests.
         if (taken == 200) hold = 300;
         else hold = relaxed ? $urandom_range(0, 4) : 0;
         rsp_ready <= (hold == 0);
         stall     <= hold;
      end else if (stall > 1) begin
         stall <= stall - 1;
      end else begin
         stall     <= 0;
         rsp_ready <= 1'b1;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus.
   // ---------------------------------------------------------------------
   task automatic push_byte(logic [7:0] b);
      vt52_pkg::req_type q;
      q = '0;
      q.byte_in  = b;
      q.read_row = vt52_pkg::ROW_W'($urandom);
      q.read_col = vt52_pkg::COL_W'($urandom);
      host_queue.push_back(q);
   endtask

   task automatic push_read(int r, int c);
      vt52_pkg::req_type q;
      q.kind     = 1'b1;
      q.byte_in  = 8'($urandom);
      q.read_row = vt52_pkg::ROW_W'(r);
      q.read_col = vt52_pkg::COL_W'(c);
      host_queue.push_back(q);
   endtask

   task automatic drain();
      while (host_queue.size() > 0 || req_valid || due_rsp.size() > 0) @(posedge clock);
   endtask

   // Writes every register; the engine is idle here.
   task automatic set_config(int cols, int rows, int tw, int sp, int bse);
      logic [vt52_pkg::COL_W-1:0] v[5];
      v[0] = vt52_pkg::COL_W'(cols);
      v[1] = vt52_pkg::COL_W'(rows);
      v[2] = vt52_pkg::COL_W'(tw);
      v[3] = vt52_pkg::COL_W'(sp);
      v[4] = vt52_pkg::COL_W'(bse);
      for (int i = 0; i < 5; i++) begin
         @(posedge clock);
         csr_we    <= 1'b1;
         csr_index <= vt52_pkg::CSR_IDX_W'(i);
         csr_wdata <= v[i];
      end
      @(posedge clock);
      csr_we <= 1'b0;
      cfg.screen_columns    = v[0];
      cfg.screen_rows       = v[1][vt52_pkg::ROW_W-1:0];
      cfg.tab_width         = v[2];
      cfg.tab_writes_spaces = v[3][0];
      cfg.backspace_erases  = v[4][0];
      clamp_cursor();
   endtask

   // Mostly well-formed escape sequences and text, with some noise and
   // broken sequences mixed in.
   task automatic random_traffic(int count);
      logic [7:0] letters[27] = '{vt52_pkg::LT_FG, vt52_pkg::LT_BG, vt52_pkg::LT_SETF,
         vt52_pkg::LT_CLRF, vt52_pkg::LT_ADDR, vt52_pkg::LT_ERASE_SOP, vt52_pkg::LT_SHOW,
         vt52_pkg::LT_HIDE, vt52_pkg::LT_SAVE, vt52_pkg::LT_RESTORE, vt52_pkg::LT_ERASE_LN,
         vt52_pkg::LT_ERASE_SOL, vt52_pkg::LT_SO_ON, vt52_pkg::LT_SO_OFF,
         vt52_pkg::LT_WRAP_ON, vt52_pkg::LT_WRAP_OFF, vt52_pkg::LT_UP, vt52_pkg::LT_DOWN,
         vt52_pkg::LT_RIGHT, vt52_pkg::LT_LEFT, vt52_pkg::LT_CLEAR, vt52_pkg::LT_HOME,
         vt52_pkg::LT_RINDEX, vt52_pkg::LT_ERASE_EOP, vt52_pkg::LT_ERASE_EOL,
         vt52_pkg::LT_INS_LINE, vt52_pkg::LT_DEL_LINE};
      logic [7:0] ctrls[6] = '{vt52_pkg::CH_BEL, vt52_pkg::CH_BS, vt52_pkg::CH_TAB,
         vt52_pkg::CH_LF, vt52_pkg::CH_CR, vt52_pkg::CH_NUL};
      int start, pick;
      logic [7:0] arg;
      start = host_queue.size();
      while (host_queue.size() - start < count) begin
         pick = $urandom_range(0, 99);
         if (pick < 35) push_byte(8'($urandom_range(32, 255)));
         else if (pick < 47) push_byte(ctrls[$urandom_range(0, 5)]);
         else if (pick < 50) push_byte(8'($urandom));
         else if (pick < 72) begin
            push_byte(vt52_pkg::CH_ESC);
            arg = letters[$urandom_range(0, 26)];
            // Keep full-screen clears rare so the run stays short.
            if (arg == vt52_pkg::LT_CLEAR && $urandom_range(0, 3) != 0) arg = vt52_pkg::LT_HOME;
            push_byte(arg);
            if (arg == vt52_pkg::LT_FG || arg == vt52_pkg::LT_BG ||
                arg == vt52_pkg::LT_SETF || arg == vt52_pkg::LT_CLRF)
               push_byte(8'($urandom));
            else if (arg == vt52_pkg::LT_ADDR) begin
               push_byte(8'($urandom_range(16, 140)));
               push_byte(8'($urandom_range(16, 140)));
            end
         end else if (pick < 80) begin
            push_byte(vt52_pkg::CH_ESC);
            push_byte(vt52_pkg::LT_ADDR);
            push_byte(8'($urandom_range(0, 255)));
            push_byte(8'($urandom_range(0, 255)));
         end else if (pick < 86) begin
            push_byte(vt52_pkg::CH_ESC);
            push_byte(($urandom_range(0, 1) != 0) ? vt52_pkg::CH_ESC : 8'($urandom));
         end else if (pick < 96) push_read($urandom_range(0, 24), $urandom_range(0, 79));
         else push_read($urandom_range(0, 31), $urandom_range(0, 127));
      end
   endtask

   initial begin
      wipe_store();
      cur_c = '0; cur_r = '0; sav_c = '0; sav_r = '0;
      wattr = '0; wrap_on = 1'b1; shown = 1'b1; phase = vt52_pkg::PH_TEXT;
      row_byte = '0; fg = '0; bg = '0;
      cfg.screen_columns = 7'd80;
      cfg.screen_rows = 5'd25;
      cfg.tab_width = 7'd8;
      cfg.tab_writes_spaces = 1'b0;
      cfg.backspace_erases = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed part at the reset settings.
      push_byte(8'h41); push_byte(8'hFF); push_byte(vt52_pkg::CH_NUL);
      push_byte(vt52_pkg::CH_BEL);
      push_byte(vt52_pkg::CH_TAB); push_byte(vt52_pkg::CH_BS); push_byte(vt52_pkg::CH_CR);
      push_byte(vt52_pkg::CH_LF);
      push_byte(vt52_pkg::CH_ESC); push_byte(vt52_pkg::LT_ADDR); push_byte(8'h00);
      push_byte(8'hFF);
      push_byte(vt52_pkg::CH_ESC); push_byte(vt52_pkg::LT_FG); push_byte(8'hFF);
      push_byte(vt52_pkg::CH_ESC); push_byte(vt52_pkg::LT_SETF); push_byte(8'hFF);
      push_byte(vt52_pkg::CH_ESC); push_byte(8'h78);   // unknown letter
      // Reverse index at the top row.
      push_byte(vt52_pkg::CH_ESC); push_byte(vt52_pkg::LT_RINDEX);
      push_read(0, 79); push_read(31, 127); push_read(1, 0);
      drain();
      random_traffic(140);
      drain();

      // Zero sizes act as one; erasing backspace wraps in a single column.
      relaxed = 1'b0;
      set_config(0, 0, 0, 1, 1);
      random_traffic(110);
      drain();

      // Sizes above the maximum act as the maximum.
      relaxed = 1'b1;
      set_config(127, 31, 127, 1, 0);
      random_traffic(90);
      drain();

      set_config(10, 4, 3, 1, 1);
      random_traffic(160);
      drain();

      set_config(1, 25, 1, 0, 1);
      random_traffic(100);
      drain();

      set_config(80, 2, 80, 0, 0);
      random_traffic(130);
      drain();

      repeat (50) @(posedge clock);
      if (errors == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end

   initial begin
      #50000000;
      $display("FAIL");
      $finish;
   end

endmodule
`default_nettype wire
